// ----- hdl/etpr_pkg.sv -----
// shared widths, codes, register defaults and state type of the edge to pcm resampler
package etpr_pkg;

  // field widths fixed by the channel formats
  localparam int OP_W        = 2;
  localparam int EDGE_TIME_W = 48;
  localparam int STATUS_W    = 3;
  localparam int PCM_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;
  localparam int MRATE_W     = 32;
  localparam int SRATE_W     = 20;
  localparam int START_W     = 48;
  // a sample lasts at most the whole tick rate plus one tick
  localparam int DUR_W       = MRATE_W + 1;

  // parameter defaults
  localparam int FULL_SCALE_DEF = 32767;
  localparam int TIME_BITS_DEF  = 48;

  // register reset values
  localparam logic [MRATE_W-1:0] MRATE_RST = 32'd3500000;
  localparam logic [SRATE_W-1:0] SRATE_RST = 20'd44100;

  // saturation limits of the signed sample
  localparam logic [PCM_W-1:0] PCM_POS_MAX = 16'h7fff;
  localparam logic [PCM_W-1:0] PCM_NEG_MAG = 16'h8000;

  // request operation codes
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
  localparam logic [OP_W-1:0] OP_EMIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MRATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 2'd3;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_STARTED       = 3'd0,
    STS_EDGE_TAKEN    = 3'd1,
    STS_SAMPLE_READY  = 3'd2,
    STS_EDGE_AHEAD    = 3'd3,
    STS_OUT_OF_ORDER  = 3'd4,
    STS_BAD_CONFIG    = 3'd5,
    STS_NOT_STARTED   = 3'd6,
    STS_TIME_OVERFLOW = 3'd7
  } status_t;

  // control sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_START_DIV,
    S_OPEN_SPREAD,
    S_OPEN_CHECK,
    S_EDGE_CHECK,
    S_EDGE_ADD,
    S_EMIT_ADD,
    S_EMIT_MAG,
    S_EMIT_MUL,
    S_EMIT_SUM,
    S_EMIT_DIV,
    S_EMIT_SAT,
    S_DONE
  } state_t;

endpackage

// ----- hdl/etpr_channels.sv -----
// valid/ready channel interfaces for edge requests, pcm results and register writes

interface etpr_event_if import etpr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [EDGE_TIME_W-1:0] edge_time;
  logic                   edge_level;

  modport source (output valid, op, edge_time, edge_level, input ready);
  modport sink (input valid, op, edge_time, edge_level, output ready);
endinterface

interface etpr_sample_if import etpr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [PCM_W-1:0] pcm_value;

  modport source (output valid, status, pcm_value, input ready);
  modport sink (input valid, status, pcm_value, output ready);
endinterface

interface etpr_cfg_if import etpr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/etpr_mul.sv -----
// bit-serial multiplier of an operand by the constant full scale, lsb first
module etpr_mul import etpr_pkg::*; #(
  parameter int A_W        = DUR_W,
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [A_W-1:0]                                a,
  output logic                                          done,
  output logic [A_W+$clog2(64'(FULL_SCALE)+64'd1)-1:0]  product
);

  localparam int FS_W  = $clog2(64'(FULL_SCALE) + 64'd1);
  localparam int CNT_W = $clog2(FS_W + 1);
  localparam logic [FS_W-1:0] FS_BITS = FS_W'(FULL_SCALE);

  logic [CNT_W-1:0] left;
  logic [FS_W-1:0]  fs_sr;
  logic [A_W-1:0]   a_q;
  logic [A_W:0]     hi;
  logic [A_W:0]     sum;
  logic [FS_W-1:0]  lo;

  // one partial product per cycle
  assign sum     = hi + (fs_sr[0] ? {1'b0, a_q} : '0);
  assign product = {hi[A_W-1:0], lo};

  // step counter and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      done <= 1'b0;
    end else begin
      done <= (left == CNT_W'(1));
      if (start) begin
        left <= CNT_W'(FS_W);
      end else if (left != '0) begin
        left <= left - CNT_W'(1);
      end
    end
  end

  // shift-add datapath, product bits leave the adder at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      a_q   <= a;
      fs_sr <= FS_BITS;
      hi    <= '0;
    end else if (left != '0) begin
      hi    <= {1'b0, sum[A_W:1]};
      lo    <= FS_W'({sum[0], lo} >> 1);
      fs_sr <= fs_sr >> 1;
    end
  end

endmodule

// ----- hdl/etpr_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module etpr_div import etpr_pkg::*; #(
  parameter int N_W = 49,
  parameter int D_W = DUR_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient,
  output logic [D_W-1:0] remainder
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [CNT_W-1:0] left;
  logic [N_W-1:0]   num;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dsr;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             take;

  // trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem, num[N_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign take  = (trial >= {1'b0, dsr});

  assign quotient  = num;
  assign remainder = rem;

  // step counter and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      done <= 1'b0;
    end else begin
      done <= (left == CNT_W'(1));
      if (start) begin
        left <= CNT_W'(N_W);
      end else if (left != '0) begin
        left <= left - CNT_W'(1);
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (left != '0) begin
      num <= {num[N_W-2:0], take};
      rem <= take ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

endmodule

// ----- hdl/edge_to_pcm_box_resampler.sv -----
// top level: edge requests in, box-filtered signed pcm samples out
// edge request: check, then add when in order and inside the sample; start request: serial
// rate split, then spread and range check; emit request: add, multiply, divide, saturate,
// then the next sample is opened. Each goes straight to its result when not running or on
// bad settings. The next request is taken in the cycle after the result is loaded, which
// then waits in an output register. Sync reset restores defaults
module edge_to_pcm_box_resampler import etpr_pkg::*; #(
  parameter int FULL_SCALE = FULL_SCALE_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  etpr_event_if.sink    events,
  etpr_sample_if.source samples,
  etpr_cfg_if.sink      cfg
);

  localparam int FS_W  = $clog2(64'(FULL_SCALE) + 64'd1);
  localparam int NUM_W = DUR_W + FS_W + 1;
  localparam int TW    = TIME_BITS;
  localparam int SUM_W = ((TW > DUR_W) ? TW : DUR_W) + 1;

  state_t state, state_next;

  // configuration registers
  logic [MRATE_W-1:0] m_rate;
  logic [SRATE_W-1:0] s_rate;
  logic [START_W-1:0] start_cfg;
  logic               init_lvl;

  // renderer state
  logic               running;
  logic               cur_lvl;
  logic [TW-1:0]      sample_start;
  logic [TW-1:0]      sample_end;
  logic [TW-1:0]      seg_begin;
  logic [TW-1:0]      last_edge;
  logic [DUR_W-1:0]   high_t;
  logic [DUR_W-1:0]   low_t;
  logic [DUR_W-1:0]   dur;
  logic [MRATE_W-1:0] whole;
  logic [SRATE_W-1:0] rem_part;
  logic [SRATE_W-1:0] spread;
  logic               from_emit;

  // captured request and pending result
  logic [TW-1:0]      t_q;
  logic               lvl_q;
  logic [DUR_W-1:0]   dur_new;
  logic               neg_q;
  status_t            res_status;
  logic [PCM_W-1:0]   res_pcm;

  // output register
  logic               o_valid;
  status_t            o_status;
  logic [PCM_W-1:0]   o_pcm;

  // handshakes
  logic accept;
  logic cfg_write;
  logic out_free;
  logic load_out;
  logic cfg_bad;

  // arithmetic units
  logic                 mul_start;
  logic                 mul_done;
  logic [NUM_W-2:0]     mul_product;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_dividend;
  logic [DUR_W-1:0]     div_divisor;
  logic [NUM_W-1:0]     div_quot;
  logic [DUR_W-1:0]     div_rem;

  // combinational datapath terms
  logic [SRATE_W-1:0] thr;
  logic               spread_take;
  logic [SUM_W-1:0]   open_sum;
  logic               open_ok;
  logic               edge_older;
  logic               edge_ahead;
  logic [DUR_W-1:0]   edge_delta;
  logic [DUR_W-1:0]   end_delta;
  logic               mag_neg;
  logic [DUR_W-1:0]   mag;
  logic [NUM_W-1:0]   num;
  logic [PCM_W-1:0]   mag16;
  logic [PCM_W-1:0]   pcm_sat;

  assign accept    = events.valid && events.ready;
  assign cfg_write = cfg.valid && cfg.ready;
  assign out_free  = !o_valid || samples.ready;

  assign cfg.ready         = 1'b1;
  assign samples.valid     = o_valid;
  assign samples.status    = o_status;
  assign samples.pcm_value = $signed(o_pcm);

  // settings check at start
  assign cfg_bad = (m_rate == '0) || (s_rate == '0) || (MRATE_W'(s_rate) > m_rate);

  // spreading of the remainder ticks
  assign thr         = (s_rate > rem_part) ? (s_rate - rem_part) : '0;
  assign spread_take = (spread >= thr);

  // end of the next sample and range check
  assign open_sum = SUM_W'(sample_start) + SUM_W'(dur_new);
  assign open_ok  = (dur_new != '0) && (open_sum[SUM_W-1:TW] == '0);

  // edge ordering checks and tick counts
  assign edge_older = (t_q < last_edge);
  assign edge_ahead = (t_q >= sample_end);
  assign edge_delta = DUR_W'(t_q - seg_begin);
  assign end_delta  = DUR_W'(sample_end - seg_begin);

  // magnitude of high minus low
  assign mag_neg = (low_t > high_t);
  assign mag     = mag_neg ? (low_t - high_t) : (high_t - low_t);

  // rounded numerator: scaled magnitude plus half the duration
  assign num = NUM_W'(mul_product) + NUM_W'(dur >> 1);

  // saturation and sign restore
  always_comb begin
    mag16 = (div_quot > NUM_W'(PCM_NEG_MAG)) ? PCM_NEG_MAG : div_quot[PCM_W-1:0];
    if (dur == '0) begin
      pcm_sat = '0;
    end else if (neg_q) begin
      pcm_sat = '0 - mag16;
    end else if (div_quot > NUM_W'(PCM_POS_MAX)) begin
      pcm_sat = PCM_POS_MAX;
    end else begin
      pcm_sat = div_quot[PCM_W-1:0];
    end
  end

  // scaling multiplier
  etpr_mul #(
    .A_W        (DUR_W),
    .FULL_SCALE (FULL_SCALE)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mag),
    .done    (mul_done),
    .product (mul_product)
  );

  // divider shared by the rate split and the averaging
  etpr_div #(
    .N_W (NUM_W),
    .D_W (DUR_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (events.op)
            OP_START: state_next = cfg_bad ? S_DONE : S_START_DIV;
            OP_EDGE:  state_next = running ? S_EDGE_CHECK : S_DONE;
            OP_EMIT:  state_next = running ? S_EMIT_ADD : S_DONE;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_START_DIV:   if (div_done) state_next = S_OPEN_SPREAD;
      S_OPEN_SPREAD: state_next = S_OPEN_CHECK;
      S_OPEN_CHECK:  state_next = S_DONE;
      S_EDGE_CHECK:  state_next = (edge_older || edge_ahead) ? S_DONE : S_EDGE_ADD;
      S_EDGE_ADD:    state_next = S_DONE;
      S_EMIT_ADD:    state_next = S_EMIT_MAG;
      S_EMIT_MAG:    state_next = S_EMIT_MUL;
      S_EMIT_MUL:    if (mul_done) state_next = S_EMIT_SUM;
      S_EMIT_SUM:    state_next = S_EMIT_DIV;
      S_EMIT_DIV:    if (div_done) state_next = S_EMIT_SAT;
      S_EMIT_SAT:    state_next = S_OPEN_SPREAD;
      S_DONE:        if (out_free) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    events.ready = (state == S_IDLE);
    mul_start    = (state == S_EMIT_MAG);
    div_start    = (accept && (events.op == OP_START) && !cfg_bad) || (state == S_EMIT_SUM);
    load_out     = (state == S_DONE) && out_free;
    if (state == S_EMIT_SUM) begin
      div_dividend = num;
      div_divisor  = dur;
    end else begin
      div_dividend = NUM_W'(m_rate);
      div_divisor  = DUR_W'(s_rate);
    end
  end

  // control and renderer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_rate       <= MRATE_RST;
      s_rate       <= SRATE_RST;
      start_cfg    <= '0;
      init_lvl     <= 1'b0;
      running      <= 1'b0;
      cur_lvl      <= 1'b0;
      sample_start <= '0;
      sample_end   <= '0;
      seg_begin    <= '0;
      last_edge    <= '0;
      high_t       <= '0;
      low_t        <= '0;
      dur          <= '0;
      whole        <= '0;
      rem_part     <= '0;
      spread       <= '0;
      from_emit    <= 1'b0;
      o_valid      <= 1'b0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg_write) begin
        case (cfg.index)
          CFG_MRATE: m_rate    <= cfg.data[MRATE_W-1:0];
          CFG_SRATE: s_rate    <= cfg.data[SRATE_W-1:0];
          CFG_START: start_cfg <= cfg.data[START_W-1:0];
          CFG_LEVEL: init_lvl  <= cfg.data[0];
          default:   ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept && (events.op == OP_START)) begin
            running   <= 1'b0;
            from_emit <= 1'b0;
          end
        end
        S_START_DIV: begin
          if (div_done) begin
            whole        <= div_quot[MRATE_W-1:0];
            rem_part     <= div_rem[SRATE_W-1:0];
            spread       <= '0;
            cur_lvl      <= init_lvl;
            sample_start <= TW'(start_cfg);
            last_edge    <= '0;
          end
        end
        S_OPEN_SPREAD: begin
          spread <= spread_take ? (spread - thr) : (spread + rem_part);
        end
        S_OPEN_CHECK: begin
          running <= open_ok;
          if (open_ok) begin
            dur        <= dur_new;
            sample_end <= open_sum[TW-1:0];
            seg_begin  <= sample_start;
            high_t     <= '0;
            low_t      <= '0;
          end
        end
        S_EDGE_ADD: begin
          if (t_q > seg_begin) begin
            if (cur_lvl) begin
              high_t <= high_t + edge_delta;
            end else begin
              low_t <= low_t + edge_delta;
            end
            seg_begin <= t_q;
          end
          cur_lvl   <= lvl_q;
          last_edge <= t_q;
        end
        S_EMIT_ADD: begin
          if (cur_lvl) begin
            high_t <= high_t + end_delta;
          end else begin
            low_t <= low_t + end_delta;
          end
        end
        S_EMIT_SAT: begin
          sample_start <= sample_end;
          from_emit    <= 1'b1;
        end
        default: ;
      endcase

      // output slot
      if (load_out) begin
        o_valid <= 1'b1;
      end else if (samples.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      t_q        <= TW'(events.edge_time);
      lvl_q      <= events.edge_level;
      res_pcm    <= '0;
      res_status <= (events.op == OP_START) ? STS_BAD_CONFIG : STS_NOT_STARTED;
    end
    case (state)
      S_EDGE_CHECK: begin
        if (edge_older) begin
          res_status <= STS_OUT_OF_ORDER;
        end else if (edge_ahead) begin
          res_status <= STS_EDGE_AHEAD;
        end else begin
          res_status <= STS_EDGE_TAKEN;
        end
      end
      S_OPEN_SPREAD: begin
        dur_new <= spread_take ? (DUR_W'(whole) + DUR_W'(1)) : DUR_W'(whole);
      end
      S_OPEN_CHECK: begin
        if (from_emit) begin
          res_status <= STS_SAMPLE_READY;
        end else begin
          res_status <= open_ok ? STS_STARTED : STS_TIME_OVERFLOW;
        end
      end
      S_EMIT_MAG: neg_q <= mag_neg;
      S_EMIT_SAT: res_pcm <= pcm_sat;
      default: ;
    endcase
    if (load_out) begin
      o_status <= res_status;
      o_pcm    <= res_pcm;
    end
  end

endmodule

// ----- tb/testbench.sv -----
// testbench for the edge to pcm resampler: directed and random streams, box filter predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import etpr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
  localparam logic [47:0]     TICK_MAX      = '1;
  localparam int              RANDOM_ITEMS  = 1550;
  localparam int              SETTLE_CYCLES = 100;
  localparam int              QUIET_LIMIT   = 2000;
  localparam int              REPORT_LINES  = 20;

  typedef struct packed {
    status_t           status;
    logic [PCM_W-1:0]  pcm;
  } sample_t;

  logic clk = 1'b0;
  logic rst;

  etpr_event_if  ev_if ();
  etpr_sample_if smp_if ();
  etpr_cfg_if    cfg_if ();

  edge_to_pcm_box_resampler i_dut (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_if),
    .samples (smp_if),
    .cfg     (cfg_if)
  );

  always #5 clk = ~clk;

  // expected results, oldest first
  sample_t samples_due [$];

  // copies of the registers
  logic [MRATE_W-1:0] tick_rate;
  logic [SRATE_W-1:0] pcm_rate;
  logic [START_W-1:0] first_tick;
  logic               level_at_start;

  // copy of the resampler state
  bit                 run_on;
  logic               lvl_now;
  logic [47:0]        win_start, win_end, seg_from, edge_last;
  logic [63:0]        ticks_hi, ticks_lo;
  logic [DUR_W-1:0]   win_len;
  logic [31:0]        ticks_whole;
  logic [19:0]        ticks_frac, frac_acc;

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int pcm_seen     = 0;
  int phases       = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;

  logic [15:0] stall_cnt  = '0;
  logic [1:0]  stall_mode = '0;

  // one line per mismatch, printing capped
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= REPORT_LINES)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic logic [47:0] any_tick();
    return {16'($urandom), $urandom};
  endfunction

  function automatic void count_ticks(logic [63:0] ticks);
    if (lvl_now) ticks_hi += ticks;
    else ticks_lo += ticks;
  endfunction

  // opens the sample at win_start, spreading the remainder ticks
  function automatic bit open_window();
    logic [19:0]      thr;
    logic [DUR_W-1:0] dur;
    thr = (pcm_rate > ticks_frac) ? pcm_rate - ticks_frac : '0;
    dur = {1'b0, ticks_whole};
    if (frac_acc >= thr) begin
      dur      = dur + 1'b1;
      frac_acc = frac_acc - thr;
    end else begin
      frac_acc = frac_acc + ticks_frac;
    end
    if (dur == '0 || 64'(dur) > 64'(TICK_MAX - win_start)) return 1'b0;
    win_len  = dur;
    win_end  = win_start + 48'(dur);
    seg_from = win_start;
    ticks_hi = '0;
    ticks_lo = '0;
    return 1'b1;
  endfunction

  // rounded, signed and saturated average of the level over the sample
  function automatic logic [PCM_W-1:0] box_average(logic [63:0] hi, logic [63:0] lo,
                                                   logic [63:0] dur);
    logic        neg;
    logic [63:0] mag, q;
    neg = lo > hi;
    mag = neg ? lo - hi : hi - lo;
    if (dur == '0) return '0;
    q = (mag * 64'(FULL_SCALE_DEF) + dur / 2) / dur;
    if (neg) begin
      if (q > 64'(PCM_NEG_MAG)) q = 64'(PCM_NEG_MAG);
      return 16'(64'h1_0000 - q);
    end
    if (q > 64'(PCM_POS_MAX)) q = 64'(PCM_POS_MAX);
    return q[PCM_W-1:0];
  endfunction

  // predicts the result of one accepted request
  task automatic box_filter_step(logic [OP_W-1:0] op, logic [47:0] t, logic lvl);
    sample_t res;
    res.pcm = '0;
    if (op == OP_UNUSED) return;
    if (op == OP_START) begin
      run_on = 1'b0;
      if (tick_rate == '0 || pcm_rate == '0 || 32'(pcm_rate) > tick_rate) begin
        res.status = STS_BAD_CONFIG;
      end else begin
        ticks_whole = tick_rate / 32'(pcm_rate);
        ticks_frac  = 20'(tick_rate % 32'(pcm_rate));
        frac_acc    = '0;
        lvl_now     = level_at_start;
        win_start   = first_tick;
        edge_last   = '0;
        if (open_window()) begin
          run_on     = 1'b1;
          res.status = STS_STARTED;
        end else begin
          res.status = STS_TIME_OVERFLOW;
        end
      end
    end else if (!run_on) begin
      res.status = STS_NOT_STARTED;
    end else if (op == OP_EDGE) begin
      if (t < edge_last) begin
        res.status = STS_OUT_OF_ORDER;
      end else if (t >= win_end) begin
        res.status = STS_EDGE_AHEAD;
      end else begin
        if (t > seg_from) begin
          count_ticks(64'(t - seg_from));
          seg_from = t;
        end
        lvl_now    = lvl;
        edge_last  = t;
        res.status = STS_EDGE_TAKEN;
      end
    end else begin
      count_ticks(64'(win_end - seg_from));
      res.pcm    = box_average(ticks_hi, ticks_lo, 64'(win_len));
      res.status = STS_SAMPLE_READY;
      win_start  = win_end;
      if (!open_window()) run_on = 1'b0;
    end
    samples_due.push_back(res);
  endtask

  // one request in bursts with random gaps
  task automatic send_request(logic [OP_W-1:0] op, logic [47:0] t = '0, logic lvl = 1'b0);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7:       gap = $urandom_range(13, 90);
        default:       gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        ev_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    ev_if.valid      <= 1'b1;
    ev_if.op         <= op;
    ev_if.edge_time  <= t;
    ev_if.edge_level <= lvl;
    @(posedge clk);
    while (!ev_if.ready) @(posedge clk);
    box_filter_step(op, t, lvl);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // waits until every result is in and the block has gone quiet
  task automatic settle();
    ev_if.valid <= 1'b0;
    burst_left = 0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_MRATE: tick_rate      = data[MRATE_W-1:0];
      CFG_SRATE: pcm_rate       = data[SRATE_W-1:0];
      CFG_START: first_tick     = data[START_W-1:0];
      default:   level_at_start = data[0];
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(logic [31:0] m, logic [19:0] r, logic [47:0] s, logic l);
    write_reg(CFG_MRATE, 48'(m));
    write_reg(CFG_SRATE, 48'(r));
    write_reg(CFG_START, s);
    write_reg(CFG_LEVEL, 48'(l));
  endtask

  // edge time inside the open sample, never before the last edge
  function automatic logic [47:0] tick_in_window(int left);
    logic [47:0] lo;
    logic [63:0] span, off;
    lo   = (edge_last > seg_from) ? edge_last : seg_from;
    span = 64'(win_end - lo);
    off  = {$urandom, $urandom} % span;
    if (left > 1 && $urandom_range(0, 1)) off = off / left;
    return lo + 48'(off);
  endfunction

  // malformed or odd requests mixed into the streams
  task automatic send_noise();
    logic [47:0] t;
    case ($urandom_range(0, 5))
      0: t = edge_last - 48'($urandom_range(1, 50));
      1: t = win_end + 48'($urandom_range(0, 100));
      2: t = any_tick();
      3: t = (seg_from > edge_last) ?
             edge_last + 48'({$urandom, $urandom} % 64'(seg_from - edge_last)) : edge_last;
      4: t = (seg_from != '0) ? seg_from - 1'b1 : '0;
      default: begin
        send_request(OP_UNUSED, any_tick(), 1'($urandom));
        return;
      end
    endcase
    send_request(OP_EDGE, t, 1'($urandom));
  endtask

  // requests before any start, and an ignored operation
  task automatic test_idle_requests();
    send_request(OP_EDGE, 48'd10, 1'b1);
    send_request(OP_EMIT);
    send_request(OP_UNUSED, TICK_MAX, 1'b1);
  endtask

  // zero rates and a sample rate above the tick rate
  task automatic test_bad_settings();
    settle();
    write_reg(CFG_MRATE, '0);
    send_request(OP_START);
    settle();
    write_reg(CFG_MRATE, 48'd100);
    write_reg(CFG_SRATE, '0);
    send_request(OP_START);
    settle();
    write_reg(CFG_SRATE, 48'd101);
    send_request(OP_START);
    send_request(OP_EDGE, 48'd5, 1'b1);
  endtask

  // one sample with edges before the start, out of order, ahead and late
  task automatic test_basic_sample();
    settle();
    write_settings(MRATE_RST, SRATE_RST, 48'd1000, 1'b1);
    send_request(OP_START);
    send_request(OP_EDGE, 48'd500, 1'b0);
    send_request(OP_EDGE, 48'd400, 1'b1);
    send_request(OP_EDGE, 48'd1020, 1'b1);
    send_request(OP_EDGE, 48'd1050, 1'b0);
    send_request(OP_EDGE, 48'd1079, 1'b1);
    send_request(OP_EMIT);
    send_request(OP_EDGE, 48'd1060, 1'b1);
    send_request(OP_EMIT);
  endtask

  // rates changed while running: the spreader reads the sample rate live
  task automatic test_live_rate();
    settle();
    write_reg(CFG_SRATE, 48'd100);
    send_request(OP_EMIT);
    settle();
    write_reg(CFG_MRATE, 48'd7);
    write_reg(CFG_LEVEL, 48'd0);
    send_request(OP_EMIT);
  endtask

  // widest and narrowest rates, full scale of both signs
  task automatic test_extremes();
    settle();
    write_settings('1, 20'd1, 48'd0, 1'b1);
    send_request(OP_START);
    send_request(OP_EMIT);
    send_request(OP_EDGE, win_start, 1'b0);
    send_request(OP_EMIT);
    settle();
    write_settings(32'h000f_ffff, 20'hf_ffff, 48'h8000_0000_0000, 1'b0);
    send_request(OP_START);
    send_request(OP_EMIT);
  endtask

  // samples at the top of the time range
  task automatic test_time_overflow();
    settle();
    write_settings(32'd5, 20'd5, TICK_MAX, 1'b0);
    send_request(OP_START);
    settle();
    write_reg(CFG_START, TICK_MAX - 1'b1);
    send_request(OP_START);
    send_request(OP_EDGE, TICK_MAX, 1'b1);
    send_request(OP_EDGE, TICK_MAX - 1'b1, 1'b1);
    send_request(OP_EMIT);
    send_request(OP_EDGE, TICK_MAX - 1'b1, 1'b0);
  endtask

  // one phase: fresh settings, a start and a run of well-formed samples
  task automatic run_random_phase();
    logic [MRATE_W-1:0] m;
    logic [SRATE_W-1:0] r;
    logic [47:0]        s;
    int                 n_samples;
    settle();
    phases++;
    case ($urandom_range(0, 9))
      0: begin
        m = $urandom_range(1, 64);
        r = $urandom_range(1, m);
      end
      1: begin
        m = $urandom;
        r = $urandom_range(1, 20'hf_ffff);
      end
      2: begin
        r = $urandom_range(1, 20'hf_ffff);
        m = 32'(r) + $urandom_range(0, 3);
      end
      3: begin
        m = $urandom_range(0, 2000);
        r = 20'(m + $urandom_range(1, 5));
        if ($urandom_range(0, 1)) r = '0;
      end
      default: begin
        m = $urandom_range(1_000_000, 8_000_000);
        r = $urandom_range(8_000, 96_000);
      end
    endcase
    case ($urandom_range(0, 3))
      0: s = '0;
      1: s = any_tick();
      2: s = TICK_MAX - 48'($urandom_range(0, 4000));
      default: s = 48'($urandom_range(0, 100_000));
    endcase
    // upper data bits beyond the register width are dropped
    write_reg(CFG_MRATE, {16'($urandom), m});
    write_reg(CFG_SRATE, {28'($urandom), r});
    if ($urandom_range(0, 4) != 0) write_reg(CFG_START, s);
    if ($urandom_range(0, 4) != 0) write_reg(CFG_LEVEL, 48'($urandom_range(0, 1)));
    send_request(OP_START);
    n_samples = $urandom_range(3, 24);
    repeat (n_samples) begin
      if (!run_on) begin
        // stopped block: refused requests, sometimes a restart
        send_request($urandom_range(0, 1) ? OP_EDGE : OP_EMIT, any_tick(), 1'($urandom));
        if ($urandom_range(0, 3) == 0) send_request(OP_START);
      end else begin
        for (int k = $urandom_range(0, 4); k > 0; k--) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          if (run_on) send_request(OP_EDGE, tick_in_window(k), 1'($urandom));
        end
        // live register change between requests
        if ($urandom_range(0, 24) == 0) begin
          settle();
          write_reg(CFG_SRATE, 48'($urandom_range(0, 20'hf_ffff)));
          if ($urandom_range(0, 1)) write_reg(CFG_START, any_tick());
        end
        if ($urandom_range(0, 39) == 0) send_request(OP_START);
        send_request(OP_EMIT);
      end
    end
  endtask

  task automatic test_random_streams();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) run_random_phase();
  endtask

  // result side: stall pattern and comparison with the oldest expectation
  always @(posedge clk) begin
    sample_t want;
    stall_cnt <= stall_cnt + 1'b1;
    if (stall_cnt[7:0] == 8'hff) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    smp_if.ready <= 1'b1;
      2'd1:    smp_if.ready <= stall_cnt[1:0] != 2'd0;
      2'd2:    smp_if.ready <= 1'($urandom);
      default: smp_if.ready <= stall_cnt[4:3] == 2'd0;
    endcase
    if (!rst && smp_if.valid && smp_if.ready) begin
      results_seen++;
      if (samples_due.size() == 0) begin
        report_mismatch("result with nothing due, status", {61'b0, smp_if.status}, 64'b0);
      end else begin
        want = samples_due.pop_front();
        if (smp_if.status !== want.status)
          report_mismatch("status", {61'b0, smp_if.status}, {61'b0, want.status});
        if (smp_if.pcm_value !== want.pcm)
          report_mismatch("pcm_value", {48'b0, smp_if.pcm_value}, {48'b0, want.pcm});
        if (want.status == STS_SAMPLE_READY) pcm_seen++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((ev_if.valid && ev_if.ready) || (smp_if.valid && smp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    ev_if.valid      <= 1'b0;
    ev_if.op         <= OP_EDGE;
    ev_if.edge_time  <= '0;
    ev_if.edge_level <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_MRATE;
    cfg_if.data      <= '0;
    // register defaults and cleared state after reset
    tick_rate      = MRATE_RST;
    pcm_rate       = SRATE_RST;
    first_tick     = '0;
    level_at_start = 1'b0;
    run_on         = 1'b0;
    lvl_now        = 1'b0;
    win_start      = '0;
    win_end        = '0;
    seg_from       = '0;
    edge_last      = '0;
    ticks_hi       = '0;
    ticks_lo       = '0;
    win_len        = '0;
    ticks_whole    = '0;
    ticks_frac     = '0;
    frac_acc       = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_idle_requests();
    test_bad_settings();
    test_basic_sample();
    test_live_rate();
    test_extremes();
    test_time_overflow();
    test_random_streams();
    settle();

    $display("run covered %0d requests over %0d random setting phases", items_sent, phases);
    $display("%0d results checked, %0d of them pcm samples, %0d mismatches",
             results_seen, pcm_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
